[design/cpl_pkg.sv]
// shared types and character codes for the punctuator length decoder
// no dependencies; imported by cpl_decode and c_punctuator_length_core
package cpl_pkg;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [2:0] bytes_left;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_length;
    logic       recognized;
  } out_item_t;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

endpackage

[design/c_punctuator_length_core.sv]
// path: an accepted transaction passes the input register, then the result register, before it shows on out_item
// throughput: one transaction per cycle, set by the single decode stage between
// the input register and the result register; out_stall holds both stages
// reset: synchronous active-low rst_n clears both valid flags; payload is not reset
// top level of the punctuator length decoder; depends on cpl_pkg and cpl_decode
module c_punctuator_length_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cpl_pkg::out_item_t out_item
);
  import cpl_pkg::*;

  logic      s1_vld_r, s1_vld_nxt;
  in_item_t  s1_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r;
  out_item_t dec_result;
  logic      out_ready;
  logic      s1_ready;

  assign out_ready = !out_vld_r || !out_stall;
  assign s1_ready  = !s1_vld_r || out_ready;
  assign in_stall  = !s1_ready;

  cpl_decode u_decode (
    .item   (s1_item_r),
    .result (dec_result)
  );

  always_comb begin
    s1_vld_nxt  = s1_ready ? in_valid : s1_vld_r;
    out_vld_nxt = out_ready ? s1_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_item_r <= in_item;
    end
    if (out_ready && s1_vld_r) begin
      out_item_r <= dec_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  a_flag_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.recognized == (out_item_r.token_length != LEN_NONE)))
    else $error("recognized flag disagrees with token length");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.token_length <= LEN_FOUR))
    else $error("token length out of range");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_ready) |=> out_vld_r)
    else $error("decoded transaction lost between stages");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_ready) |=> (s1_vld_r && $stable(s1_item_r)))
    else $error("input stage changed while blocked");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (s1_vld_r && s1_item_r == $past(in_item)))
    else $error("accepted transaction not captured");

endmodule

[design/cpl_decode.sv]
// combinational longest-match decode of one lookahead window
// depends on cpl_pkg for the item types and character codes
module cpl_decode (
  input  cpl_pkg::in_item_t  item,
  output cpl_pkg::out_item_t result
);
  import cpl_pkg::*;

  logic       h1, h2, h3;
  logic [7:0] b0, b1, b2, b3;
  logic [2:0] len;

  assign b0 = item.first_byte;
  assign b1 = item.second_byte;
  assign b2 = item.third_byte;
  assign b3 = item.fourth_byte;

  // zero counts as one and anything above four as four, which these compares already give
  assign h1 = (item.bytes_left >= 3'd2);
  assign h2 = (item.bytes_left >= 3'd3);
  assign h3 = (item.bytes_left >= 3'd4);

  always_comb begin
    unique case (b0) inside
      CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
      CH_TILDE, CH_QUEST, CH_SEMI, CH_COMMA: begin
        len = LEN_ONE;
      end
      CH_DOT: begin
        len = (h2 && b1 == CH_DOT && b2 == CH_DOT) ? LEN_THREE : LEN_ONE;
      end
      CH_LT: begin
        if (h1 && b1 == CH_LT) begin
          len = (h2 && b2 == CH_EQ) ? LEN_THREE : LEN_TWO;
        end else begin
          len = (h1 && (b1 == CH_EQ || b1 == CH_COLON || b1 == CH_PCT)) ? LEN_TWO : LEN_ONE;
        end
      end
      CH_GT: begin
        if (h1 && b1 == CH_GT) begin
          len = (h2 && b2 == CH_EQ) ? LEN_THREE : LEN_TWO;
        end else begin
          len = (h1 && b1 == CH_EQ) ? LEN_TWO : LEN_ONE;
        end
      end
      CH_PCT: begin
        // %:%: digraph needs all four bytes
        if (h1 && b1 == CH_COLON) begin
          len = (h3 && b2 == CH_PCT && b3 == CH_COLON) ? LEN_FOUR : LEN_TWO;
        end else begin
          len = (h1 && (b1 == CH_EQ || b1 == CH_GT)) ? LEN_TWO : LEN_ONE;
        end
      end
      CH_MINUS: begin
        len = (h1 && (b1 == CH_MINUS || b1 == CH_GT || b1 == CH_EQ)) ? LEN_TWO : LEN_ONE;
      end
      CH_AMP: begin
        len = (h1 && (b1 == CH_AMP || b1 == CH_EQ)) ? LEN_TWO : LEN_ONE;
      end
      CH_PLUS: begin
        len = (h1 && (b1 == CH_PLUS || b1 == CH_EQ)) ? LEN_TWO : LEN_ONE;
      end
      CH_PIPE: begin
        len = (h1 && (b1 == CH_PIPE || b1 == CH_EQ)) ? LEN_TWO : LEN_ONE;
      end
      CH_COLON: begin
        len = (h1 && b1 == CH_GT) ? LEN_TWO : LEN_ONE;
      end
      CH_HASH: begin
        len = (h1 && b1 == CH_HASH) ? LEN_TWO : LEN_ONE;
      end
      CH_STAR, CH_BANG, CH_EQ, CH_CARET, CH_SLASH: begin
        len = (h1 && b1 == CH_EQ) ? LEN_TWO : LEN_ONE;
      end
      default: begin
        len = LEN_NONE;
      end
    endcase
  end

  assign result.token_length = len;
  assign result.recognized   = (len != LEN_NONE);

endmodule
